[sv/dtcb_pkg.sv]
// shared types and constants of the depth tested character buffer
`default_nettype none

package dtcb_pkg;

    typedef logic [7:0]        char_t;
    typedef logic signed [31:0] depth_t;

    typedef enum logic [1:0] {
        REQ_WRITE     = 2'd0,
        REQ_CLEAR     = 2'd1,
        REQ_READ      = 2'd2,
        REQ_CLEAR_ALL = 2'd3
    } req_type_t;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [7:0] WIDTH_RESET  = 8'd128;
    localparam logic [6:0] HEIGHT_RESET = 7'd64;

    localparam char_t  BLANK_CHAR  = 8'h20;
    localparam depth_t BLANK_DEPTH = 32'shFFFF0000;

    typedef struct packed {
        logic   empty;
        char_t  ch;
        depth_t depth;
    } entry_t;

    localparam entry_t BLANK_ENTRY = '{empty: 1'b1, ch: BLANK_CHAR, depth: BLANK_DEPTH};

    typedef struct packed {
        req_type_t req_type;
        char_t     new_char;
        depth_t    new_depth;
        logic      force_write;
        logic      bad_position;
    } cmd_t;

    typedef struct packed {
        logic   was_written;
        char_t  read_char;
        depth_t read_depth;
        logic   read_empty;
        logic   bad_position;
    } rsp_t;

endpackage

`default_nettype wire

[sv/dtcb_ifs.sv]
// request and result channel interfaces
`default_nettype none

interface dtcb_req_if import dtcb_pkg::*; ();
    logic      valid;
    logic      ready;
    req_type_t req_type;
    logic [6:0] pos_x;
    logic [5:0] pos_y;
    char_t     new_char;
    depth_t    new_depth;
    logic      force_write;

    modport source (
        output valid, req_type, pos_x, pos_y, new_char, new_depth, force_write,
        input  ready
    );
    modport sink (
        input  valid, req_type, pos_x, pos_y, new_char, new_depth, force_write,
        output ready
    );
endinterface

interface dtcb_rsp_if import dtcb_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   was_written;
    char_t  read_char;
    depth_t read_depth;
    logic   read_empty;
    logic   bad_position;

    modport source (
        output valid, was_written, read_char, read_depth, read_empty, bad_position,
        input  ready
    );
    modport sink (
        input  valid, was_written, read_char, read_depth, read_empty, bad_position,
        output ready
    );
endinterface

`default_nettype wire

[sv/dtcb_front.sv]
// front end: configuration registers, request acceptance, address and range check
`default_nettype none

module dtcb_front import dtcb_pkg::*; #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64,
    parameter int AW         = 13
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dtcb_req_if.sink              req,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  init_busy,
    input  logic                  q_ready,
    output logic                  push,
    output cmd_t                  push_cmd,
    output logic [AW-1:0]         push_addr
);

    logic [7:0]  width_reg;
    logic [6:0]  height_reg;
    logic [31:0] used_w;
    logic [31:0] used_h;
    logic [31:0] lin;
    logic [31:0] last_addr;
    logic        bad;
    logic        clear_all;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                REG_SCREEN_HEIGHT: height_reg <= cfg_wdata[6:0];
                default:           ;
            endcase
        end
    end

    // saturate to the usable range
    always_comb
    begin
        used_w = 32'(width_reg);
        if (used_w == 32'd0)
            used_w = 32'd1;
        if (used_w > 32'(MAX_WIDTH))
            used_w = 32'(MAX_WIDTH);
        used_h = 32'(height_reg);
        if (used_h == 32'd0)
            used_h = 32'd1;
        if (used_h > 32'(MAX_HEIGHT))
            used_h = 32'(MAX_HEIGHT);
    end

    assign bad       = (32'(req.pos_x) >= used_w) || (32'(req.pos_y) >= used_h);
    assign lin       = 32'(req.pos_x) + 32'(req.pos_y) * used_w;
    assign last_addr = used_w * used_h - 32'd1;
    assign clear_all = (req.req_type == REQ_CLEAR_ALL);

    assign req.ready = q_ready && !init_busy;
    assign push      = req.valid && req.ready;

    always_comb
    begin
        push_cmd.req_type     = req.req_type;
        push_cmd.new_char     = req.new_char;
        push_cmd.new_depth    = req.new_depth;
        push_cmd.force_write  = req.force_write;
        push_cmd.bad_position = bad && !clear_all;
        // clear all carries the last address of the area to sweep
        push_addr = clear_all ? last_addr[AW-1:0] : lin[AW-1:0];
    end

endmodule

`default_nettype wire

[sv/dtcb_queue.sv]
// two-entry queue between front and back end
`default_nettype none

module dtcb_queue import dtcb_pkg::*; #(
    parameter int AW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cmd_t          push_cmd,
    input  logic [AW-1:0] push_addr,
    output logic          ready,
    output logic          valid,
    input  logic          pop,
    output cmd_t          pop_cmd,
    output logic [AW-1:0] pop_addr
);

    cmd_t          slot_cmd_reg  [2];
    logic [AW-1:0] slot_addr_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign ready    = (count_reg != 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_cmd  = slot_cmd_reg[rd_ptr_reg];
    assign pop_addr = slot_addr_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_cmd_reg[wr_ptr_reg]  <= push_cmd;
            slot_addr_reg[wr_ptr_reg] <= push_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[sv/dtcb_back.sv]
// back end: entry store, depth test, clear sweeps and result register
`default_nettype none

module dtcb_back import dtcb_pkg::*; #(
    parameter int STORE_SIZE = 8192,
    parameter int AW         = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          pop,
    input  cmd_t          q_cmd,
    input  logic [AW-1:0] q_addr,
    output logic          init_busy,
    dtcb_rsp_if.source    rsp
);

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOK,
        ST_SWEEP
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;
    logic [AW-1:0] last_reg;
    logic [AW-1:0] last_next;
    cmd_t          cur_reg;
    cmd_t          cur_next;
    logic [AW-1:0] cur_addr_reg;
    logic [AW-1:0] cur_addr_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    rsp_t          out_data_reg;
    rsp_t          out_data_next;

    entry_t        store [STORE_SIZE];
    entry_t        rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic          hit;

    assign pop       = (state_reg == ST_IDLE) && q_valid && (!out_valid_reg || rsp.ready);
    assign mem_re    = pop;
    assign init_busy = (state_reg == ST_INIT);
    assign hit       = cur_reg.force_write || rd_data_reg.empty
                       || (cur_reg.new_depth < rd_data_reg.depth);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        cur_next       = cur_reg;
        cur_addr_next  = cur_addr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg;
        mem_wdata      = BLANK_ENTRY;
        case (state_reg)
            ST_INIT:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == last_reg)
                    state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == last_reg)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                end
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    cur_next      = q_cmd;
                    cur_addr_next = q_addr;
                    if (q_cmd.req_type == REQ_CLEAR_ALL)
                    begin
                        state_next = ST_SWEEP;
                        cnt_next   = '0;
                        last_next  = q_addr;
                    end
                    else if (q_cmd.bad_position)
                    begin
                        out_valid_next             = 1'b1;
                        out_data_next              = '0;
                        out_data_next.bad_position = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                mem_waddr      = cur_addr_reg;
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                out_data_next  = '0;
                case (cur_reg.req_type)
                    REQ_WRITE:
                    begin
                        if (hit)
                        begin
                            mem_we                    = 1'b1;
                            mem_wdata.empty           = 1'b0;
                            mem_wdata.ch              = cur_reg.new_char;
                            mem_wdata.depth           = cur_reg.new_depth;
                            out_data_next.was_written = 1'b1;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        mem_we = 1'b1;
                    end
                    REQ_READ:
                    begin
                        out_data_next.read_char  = rd_data_reg.ch;
                        out_data_next.read_depth = rd_data_reg.depth;
                        out_data_next.read_empty = rd_data_reg.empty;
                    end
                    default: ;
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= store[q_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            last_reg      <= AW'(STORE_SIZE - 1);
            cur_reg       <= '0;
            cur_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            cur_reg       <= cur_next;
            cur_addr_reg  <= cur_addr_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.was_written  = out_data_reg.was_written;
    assign rsp.read_char    = out_data_reg.read_char;
    assign rsp.read_depth   = out_data_reg.read_depth;
    assign rsp.read_empty   = out_data_reg.read_empty;
    assign rsp.bad_position = out_data_reg.bad_position;

`ifndef SYNTHESIS
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("store written while idle");

    a_look_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |-> !out_valid_reg)
        else $error("result register busy during look-up");

    a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_INIT) |=> (state_reg != ST_INIT))
        else $error("clearing pass re-entered");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT || state_reg == ST_SWEEP) |-> (cnt_reg <= last_reg))
        else $error("sweep ran past its last entry");
`endif

endmodule

`default_nettype wire

[sv/depth_tested_char_buffer.sv]
// top level of the depth tested character buffer
`default_nettype none

// Character frame store with a per-entry depth test. Requests enter a two-entry
// queue and are carried out by a back end built around one single-port-style
// store of MAX_WIDTH*MAX_HEIGHT entries. The back end does a write, clear-entry
// or read request as a store read, then a depth compare and write-back, and
// takes the next request only when the last one has finished; one with bad
// coordinates skips the compare and write-back. Clear all walks the configured
// area one entry a cycle, up to its last address, before its result appears.
// After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries (8192 by
// default) runs and no request is taken until it ends. Write the configuration
// only while the block is idle; the block itself does not enforce this.

module depth_tested_char_buffer import dtcb_pkg::*; #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dtcb_req_if.sink              req,
    dtcb_rsp_if.source            rsp,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

    logic          push;
    cmd_t          push_cmd;
    logic [AW-1:0] push_addr;
    logic          q_ready;
    logic          q_valid;
    logic          pop;
    cmd_t          q_cmd;
    logic [AW-1:0] q_addr;
    logic          init_busy;

    dtcb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .init_busy (init_busy),
        .q_ready   (q_ready),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_addr (push_addr)
    );

    dtcb_queue #(
        .AW (AW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_addr (push_addr),
        .ready     (q_ready),
        .valid     (q_valid),
        .pop       (pop),
        .pop_cmd   (q_cmd),
        .pop_addr  (q_addr)
    );

    dtcb_back #(
        .STORE_SIZE (STORE_SIZE),
        .AW         (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .pop       (pop),
        .q_cmd     (q_cmd),
        .q_addr    (q_addr),
        .init_busy (init_busy),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
